// ===== hw/rtl/i2ctbc_pkg.sv =====
// ----------------------------------------------------------------------------
// i2ctbc_pkg
// shared word types and codes of the i2c target byte controller
// ----------------------------------------------------------------------------
package i2ctbc_pkg;

    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned EVENT_W = 3;

    // shift register preload values for the acknowledge slot
    localparam logic [BYTE_W-1:0] ACK_VAL  = 8'h00;
    localparam logic [BYTE_W-1:0] NACK_VAL = 8'hFF;

    // request kinds
    localparam logic REQ_START    = 1'b0;
    localparam logic REQ_OVERFLOW = 1'b1;

    // application event codes
    localparam logic [EVENT_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EVENT_W-1:0] EV_OPEN_READ  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_OPEN_WRITE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_FETCHED    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DELIVERED  = 3'd4;

    typedef struct packed {
        logic              req_type;
        logic              sda_level;
        logic [BYTE_W-1:0] shift_data;
        logic              open_accept;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_valid;
        logic              rx_accept;
    } req_word_t;

    typedef struct packed {
        logic               load_valid;
        logic [BYTE_W-1:0]  load_value;
        logic               drive_sda;
        logic               count_one_bit;
        logic               bus_engaged;
        logic [EVENT_W-1:0] app_event;
        logic [BYTE_W-1:0]  rx_byte;
    } rsp_word_t;

endpackage

// ===== hw/rtl/i2c_target_byte_controller_core.sv =====
// ----------------------------------------------------------------------------
// i2c_target_byte_controller_core
// byte-level sequencer of an i2c target over an external shift register
// ----------------------------------------------------------------------------
// Each request word is one bus event: a start condition or a shift counter
// overflow. The core answers every request with exactly one response word
// that tells the shift logic what to preload (data byte, 0x00 ack, 0xFF nack),
// whether to drive sda, whether the counter is preset for one bit or eight,
// whether the bus stays engaged, and which event to report to the
// application. A request is held in an input register, the decision
// logic runs between that register and the response register, so a word can
// enter every cycle unless stalled; its response word is loaded into the
// response register. The sustained rate is one word per cycle while
// rsp_stall is low, set by the single registered decision pass. Both sides
// use valid/stall; while rsp_stall holds a response, the input register can
// still take one more request, and req_stall rises only once both registers
// are full, dropping in the same cycle that rsp_stall drops. The own
// address register is written through the cfg channel, which is always
// ready, and should only be changed while no request is in flight.
module i2c_target_byte_controller_core (
    input  logic                         clk,
    input  logic                         rst_n,

    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  i2ctbc_pkg::req_word_t        req_word,

    // response channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output i2ctbc_pkg::rsp_word_t        rsp_word,

    // own address write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [i2ctbc_pkg::ADDR_W-1:0] cfg_data
);
    import i2ctbc_pkg::*;

    // byte phase of the transfer
    typedef enum logic [2:0] {
        PH_ADDR       = 3'd0,
        PH_READ_DATA  = 3'd1,
        PH_READ_ACK   = 3'd2,
        PH_WRITE_DATA = 3'd3,
        PH_WRITE_ACK  = 3'd4
    } phase_t;

    phase_t             phase_reg,   phase_next;
    logic               engaged_reg, engaged_next;
    logic [ADDR_W-1:0]  own_addr_reg;

    // input register
    logic               s1_valid_reg;
    req_word_t          s1_word_reg;

    // response register
    logic               out_valid_reg;
    rsp_word_t          out_word_reg;
    rsp_word_t          out_word_next;

    logic               advance;
    logic               release_bus;

    // the input stage moves on when the response register is free or drains
    assign advance   = s1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    // decision pass for the word in the input register
    always_comb
    begin
        phase_next    = phase_reg;
        engaged_next  = engaged_reg;
        release_bus   = 1'b0;
        out_word_next = '0;

        if (s1_word_reg.req_type == REQ_START)
        begin
            // a stop right after the start leaves the bus idle
            phase_next   = PH_ADDR;
            engaged_next = !s1_word_reg.sda_level;
        end
        else if (engaged_reg)
        begin
            case (phase_reg)
                PH_ADDR:
                begin
                    if (s1_word_reg.shift_data[BYTE_W-1:1] != own_addr_reg)
                    begin
                        release_bus = 1'b1;
                    end
                    else
                    begin
                        // r/w bit picks read or write transfer
                        out_word_next.app_event     = s1_word_reg.shift_data[0] ?
                                                      EV_OPEN_READ : EV_OPEN_WRITE;
                        out_word_next.load_valid    = 1'b1;
                        out_word_next.load_value    = s1_word_reg.open_accept ?
                                                      ACK_VAL : NACK_VAL;
                        out_word_next.drive_sda     = 1'b1;
                        out_word_next.count_one_bit = 1'b1;
                        if (s1_word_reg.shift_data[0])
                        begin
                            phase_next = PH_READ_DATA;
                        end
                        else
                        begin
                            phase_next = PH_WRITE_DATA;
                        end
                    end
                end
                PH_READ_DATA:
                begin
                    // nonzero ack bits mean the controller did not ack
                    if (s1_word_reg.shift_data != ACK_VAL)
                    begin
                        release_bus = 1'b1;
                    end
                    else
                    begin
                        // fetch is reported even if the application declines
                        out_word_next.app_event = EV_FETCHED;
                        if (!s1_word_reg.tx_valid)
                        begin
                            release_bus = 1'b1;
                        end
                        else
                        begin
                            out_word_next.load_valid = 1'b1;
                            out_word_next.load_value = s1_word_reg.tx_byte;
                            out_word_next.drive_sda  = 1'b1;
                            phase_next = PH_READ_ACK;
                        end
                    end
                end
                PH_READ_ACK:
                begin
                    // release sda to sample the controller's ack bit
                    out_word_next.load_valid    = 1'b1;
                    out_word_next.load_value    = ACK_VAL;
                    out_word_next.count_one_bit = 1'b1;
                    phase_next = PH_READ_DATA;
                end
                PH_WRITE_DATA:
                begin
                    if (s1_word_reg.shift_data != ACK_VAL)
                    begin
                        release_bus = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_WRITE_ACK;
                    end
                end
                PH_WRITE_ACK:
                begin
                    out_word_next.app_event     = EV_DELIVERED;
                    out_word_next.rx_byte       = s1_word_reg.shift_data;
                    out_word_next.load_valid    = 1'b1;
                    out_word_next.load_value    = s1_word_reg.rx_accept ?
                                                  ACK_VAL : NACK_VAL;
                    out_word_next.drive_sda     = 1'b1;
                    out_word_next.count_one_bit = 1'b1;
                    phase_next = PH_WRITE_DATA;
                end
                default:
                begin
                    release_bus = 1'b1;
                end
            endcase

            if (release_bus)
            begin
                engaged_next = 1'b0;
                phase_next   = PH_ADDR;
            end
        end

        out_word_next.bus_engaged = engaged_next;
    end

    // state, input register and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ADDR;
            engaged_reg   <= 1'b0;
            own_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                own_addr_reg <= cfg_data;
            end

            if (req_valid && !req_stall)
            begin
                s1_valid_reg <= 1'b1;
                s1_word_reg  <= req_word;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg     <= phase_next;
                engaged_reg   <= engaged_next;
                out_valid_reg <= 1'b1;
                out_word_reg  <= out_word_next;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // a decided word always lands in the response register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("decided word did not reach response register");

    // the input stage only pushes back while it holds a word
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg)
        else $error("request stalled with empty input register");

    // a released bus never drives sda or preloads the shift register
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_word_reg.bus_engaged) |->
        (!out_word_reg.drive_sda && !out_word_reg.load_valid))
        else $error("sda driven or load issued on an idle bus");

    // received byte is only reported with a delivery event
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.app_event != EV_DELIVERED) |->
        (out_word_reg.rx_byte == '0))
        else $error("rx byte set without a delivery event");

    // engaged state only comes up through a start event
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(engaged_reg) |->
        ($past(advance) && $past(s1_word_reg.req_type) == REQ_START))
        else $error("bus engaged without a start event");

endmodule

// ===== tb/sv/tb_i2c_target_byte_controller_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_target_byte_controller_core
// self-checking bench for the i2c target byte controller core
// ----------------------------------------------------------------------------
// A few hand-built bus transactions come first: stop right after start,
// overflow while idle, address mismatch, full write and read transfers with
// ack and nack, a declined fetch and a repeated start. Random traffic
// follows. It is built mostly as well-formed transfers steered by the
// predicted bus phase, with a little noise mixed in. It runs under three
// pacing profiles and several own addresses, 0 and 127 among them. Every
// response word is checked field by field against a local model of the
// controller.
// ----------------------------------------------------------------------------
module tb_i2c_target_byte_controller_core;

    import i2ctbc_pkg::*;

    localparam int REQ_W        = $bits(req_word_t);
    localparam int DRAIN_CYCLES = 6;     // idle wait after the last response is back
    localparam int STALL_LIMIT  = 4000;  // cycles with no handshake at all

    // bus phase of the local model
    typedef enum logic [2:0] {
        PH_ADDR,
        PH_READ_DATA,
        PH_READ_ACK,
        PH_WRITE_DATA,
        PH_WRITE_ACK
    } bus_phase_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req_word  = '0;

    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data  = '0;

    // local model state, mirrors the controller after every accepted word
    bus_phase_t        model_phase    = PH_ADDR;
    logic              model_engaged  = 1'b0;
    logic [ADDR_W-1:0] model_own_addr = '0;

    // responses predicted but not yet seen, oldest first
    rsp_word_t pending_rsp[$];

    // pacing in percent per cycle
    int unsigned sender_idle_pct  = 0;
    int unsigned receiver_hold_pct = 0;

    int unsigned error_count  = 0;
    int unsigned words_sent   = 0;
    int unsigned words_seen   = 0;
    int unsigned quiet_cycles = 0;

    always #2 clk = ~clk;

    i2c_target_byte_controller_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // local model of the controller
    // ------------------------------------------------------------------------

    // give up the bus: nothing loaded, back to address phase
    function automatic void drop_bus();
        model_engaged = 1'b0;
        model_phase   = PH_ADDR;
    endfunction

    // expected response for one request word, advances the model state
    function automatic rsp_word_t predict_response(input req_word_t w);
        rsp_word_t r;
        r = '0;
        r.app_event = EV_NONE;
        if (w.req_type == REQ_START) begin
            // start releases sda, counter for eight bits; stop right after
            // the start leaves the target idle
            model_phase   = PH_ADDR;
            model_engaged = (w.sda_level == 1'b0);
        end
        else if (model_engaged) begin
            case (model_phase)
                PH_ADDR: begin
                    if (w.shift_data[7:1] != model_own_addr) begin
                        drop_bus();
                    end
                    else begin
                        r.app_event     = w.shift_data[0] ? EV_OPEN_READ : EV_OPEN_WRITE;
                        r.load_valid    = 1'b1;
                        r.load_value    = w.open_accept ? ACK_VAL : NACK_VAL;
                        r.drive_sda     = 1'b1;
                        r.count_one_bit = 1'b1;
                        if (w.shift_data[0]) model_phase = PH_READ_DATA;
                        else model_phase = PH_WRITE_DATA;
                    end
                end
                PH_READ_DATA: begin
                    // nonzero ack bits mean the controller did not ack
                    if (w.shift_data != '0) begin
                        drop_bus();
                    end
                    else begin
                        // the fetch is reported even when the app declines
                        r.app_event = EV_FETCHED;
                        if (!w.tx_valid) begin
                            drop_bus();
                        end
                        else begin
                            r.load_valid = 1'b1;
                            r.load_value = w.tx_byte;
                            r.drive_sda  = 1'b1;
                            model_phase  = PH_READ_ACK;
                        end
                    end
                end
                PH_READ_ACK: begin
                    r.load_valid    = 1'b1;
                    r.load_value    = ACK_VAL;
                    r.count_one_bit = 1'b1;
                    model_phase     = PH_READ_DATA;
                end
                PH_WRITE_DATA: begin
                    if (w.shift_data != '0) drop_bus();
                    else model_phase = PH_WRITE_ACK;
                end
                PH_WRITE_ACK: begin
                    r.app_event     = EV_DELIVERED;
                    r.rx_byte       = w.shift_data;
                    r.load_valid    = 1'b1;
                    r.load_value    = w.rx_accept ? ACK_VAL : NACK_VAL;
                    r.drive_sda     = 1'b1;
                    r.count_one_bit = 1'b1;
                    model_phase     = PH_WRITE_DATA;
                end
                default: drop_bus();
            endcase
        end
        // overflow while idle: all fields stay zero, state untouched
        r.bus_engaged = model_engaged;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // response side: random hold-off and field by field check
    // ------------------------------------------------------------------------

    always @(posedge clk) begin
        rsp_stall <= ($urandom_range(99) < receiver_hold_pct);
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        rsp_word_t exp_w;
        if (rst_n && rsp_valid && !rsp_stall) begin
            words_seen++;
            if (pending_rsp.size() == 0) begin
                $error("response word 0x%0h with no request pending", rsp_word);
                error_count++;
            end
            else begin
                exp_w = pending_rsp.pop_front();
                check_field("load_valid",    32'(exp_w.load_valid),
                            32'(rsp_word.load_valid));
                check_field("load_value",    32'(exp_w.load_value),
                            32'(rsp_word.load_value));
                check_field("drive_sda",     32'(exp_w.drive_sda),
                            32'(rsp_word.drive_sda));
                check_field("count_one_bit", 32'(exp_w.count_one_bit),
                            32'(rsp_word.count_one_bit));
                check_field("bus_engaged",   32'(exp_w.bus_engaged),
                            32'(rsp_word.bus_engaged));
                check_field("app_event",     32'(exp_w.app_event),
                            32'(rsp_word.app_event));
                check_field("rx_byte",       32'(exp_w.rx_byte),
                            32'(rsp_word.rx_byte));
            end
        end
    end

    // watchdog: ends a run that stops moving
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d responses pending",
                         STALL_LIMIT, pending_rsp.size());
                $display("[i2c_target_byte_controller_core] ERROR");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // hand one request word over, then log its expected response
    task automatic send_word(input req_word_t w);
        if ($urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        pending_rsp.push_back(predict_response(w));
        words_sent++;
    endtask

    // stop sending and let every pending response come back
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_own_address(input logic [ADDR_W-1:0] addr);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid      <= 1'b0;
        model_own_addr  = addr;
    endtask

    function automatic req_word_t rand_word();
        return req_word_t'(REQ_W'($urandom));
    endfunction

    task automatic send_start(input logic sda);
        req_word_t w;
        w           = rand_word();
        w.req_type  = REQ_START;
        w.sda_level = sda;
        send_word(w);
    endtask

    task automatic send_overflow(input logic [BYTE_W-1:0] sdata, input logic oacc,
                                 input logic [BYTE_W-1:0] txb, input logic txv,
                                 input logic racc);
        req_word_t w;
        w             = rand_word();
        w.req_type    = REQ_OVERFLOW;
        w.shift_data  = sdata;
        w.open_accept = oacc;
        w.tx_byte     = txb;
        w.tx_valid    = txv;
        w.rx_accept   = racc;
        send_word(w);
    endtask

    // next random word, mostly the one a real controller would cause in the
    // predicted phase, with some noise and broken transfers
    function automatic req_word_t next_bus_word();
        req_word_t w;
        w = rand_word();
        if ($urandom_range(99) < 6) return w;
        if (!model_engaged) begin
            w.req_type  = REQ_START;
            w.sda_level = ($urandom_range(9) == 0);
            return w;
        end
        // repeated start in the middle of a transfer
        if ($urandom_range(99) < 3) begin
            w.req_type  = REQ_START;
            w.sda_level = 1'b0;
            return w;
        end
        w.req_type = REQ_OVERFLOW;
        case (model_phase)
            PH_ADDR: begin
                if ($urandom_range(99) < 85) w.shift_data[7:1] = model_own_addr;
                w.open_accept = ($urandom_range(99) < 80);
            end
            PH_READ_DATA: begin
                if ($urandom_range(99) < 85) w.shift_data = '0;
                w.tx_valid = ($urandom_range(99) < 88);
            end
            PH_WRITE_DATA: begin
                if ($urandom_range(99) < 90) w.shift_data = '0;
            end
            PH_WRITE_ACK: begin
                w.rx_accept = ($urandom_range(99) < 85);
            end
            default: ;
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // stop right after start, overflow while idle, address mismatch
    task automatic test_idle_events();
        send_start(1'b1);
        send_overflow(8'h00, 1'b1, 8'hFF, 1'b1, 1'b1);
        send_start(1'b0);
        send_overflow({7'h55, 1'b0}, 1'b1, 8'h00, 1'b1, 1'b1);
    endtask

    // write to address 0: acked byte, nacked byte, then controller gives up
    task automatic test_write_transfer();
        send_start(1'b0);
        send_overflow({7'h00, 1'b0}, 1'b1, 8'h00, 1'b0, 1'b0);
        send_overflow(8'h00, 1'b0, 8'hFF, 1'b0, 1'b0);
        send_overflow(8'hFF, 1'b0, 8'h00, 1'b0, 1'b1);
        send_overflow(8'h00, 1'b1, 8'h00, 1'b1, 1'b1);
        send_overflow(8'h00, 1'b1, 8'hFF, 1'b1, 1'b0);
        send_overflow(8'h01, 1'b0, 8'h00, 1'b0, 1'b1);
    endtask

    // read from address 127: nacked open, two bytes, controller nack, then
    // an accepted open where the app has nothing to send
    task automatic test_read_transfer();
        send_start(1'b0);
        send_overflow({7'h7F, 1'b1}, 1'b0, 8'h00, 1'b0, 1'b0);
        send_overflow(8'h00, 1'b0, 8'hFF, 1'b1, 1'b0);
        send_overflow(8'hFF, 1'b1, 8'h00, 1'b0, 1'b1);
        send_overflow(8'h00, 1'b1, 8'h00, 1'b1, 1'b1);
        send_overflow(8'hAA, 1'b0, 8'h55, 1'b0, 1'b0);
        send_overflow(8'h80, 1'b1, 8'hFF, 1'b1, 1'b1);
        send_start(1'b0);
        send_overflow({7'h7F, 1'b1}, 1'b1, 8'h00, 1'b1, 1'b0);
        send_overflow(8'h00, 1'b0, 8'hFF, 1'b0, 1'b1);
    endtask

    // start inside a transfer, then a stop right after a start
    task automatic test_repeated_start();
        send_start(1'b0);
        send_overflow({7'h7F, 1'b0}, 1'b1, 8'h00, 1'b1, 1'b1);
        send_start(1'b0);
        send_start(1'b1);
    endtask

    // random transfers under one pacing profile and one own address; halfway
    // through the sender holds off until every response is back
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned hold_pct,
                                       input logic [ADDR_W-1:0] addr,
                                       input int unsigned n_words);
        req_word_t   w;
        int unsigned counted;
        counted = 0;
        write_own_address(addr);
        sender_idle_pct   = idle_pct;
        receiver_hold_pct = hold_pct;
        while (counted < n_words) begin
            w = next_bus_word();
            // overflow while idle is ignored by the core, not counted
            if (w.req_type == REQ_START || model_engaged) counted++;
            send_word(w);
            if (counted == n_words / 2) begin
                wait_idle();
                counted++;
            end
        end
    endtask

    initial begin
        sender_idle_pct   = 11;
        receiver_hold_pct = 82;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // own address still at its reset value 0
        test_idle_events();
        test_write_transfer();
        write_own_address(7'h7F);
        test_read_transfer();
        test_repeated_start();

        test_random_traffic(11, 82, 7'h00, 500);
        test_random_traffic(82, 11, 7'h7F, 500);
        test_random_traffic(0, 0, 7'($urandom_range(1, 126)), 450);

        wait_idle();
        $display("covered %0d request words and %0d response words", words_sent, words_seen);
        $display("directed bus cases, then random transfers under three pacing profiles");
        if (error_count == 0) begin
            $display("[i2c_target_byte_controller_core] OK");
        end
        else begin
            $display("%0d mismatches", error_count);
            $display("[i2c_target_byte_controller_core] ERROR");
        end
        $finish;
    end

endmodule
